// ===== src/fts_pkg.sv =====
// fts_pkg: shared types and constants for the filename token scanner
// scan phase codes, character codes, limits and the result word layout
// no dependencies
`timescale 1ns / 1ps

package fts_pkg;

  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned EXT_W    = 3;
  localparam int unsigned EXTLEN_W = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  localparam logic [COUNT_W-1:0] NAME_LIMIT_RST    = 6'd32;
  localparam logic [COUNT_W-1:0] VERSION_LIMIT_RST = 6'd34;
  localparam logic [COUNT_W-1:0] MIN_TOKEN_LEN     = 6'd5;

  localparam logic [EXT_W-1:0] EXT_SAT     = 3'd4;
  localparam logic [EXT_W-1:0] EXT_LEN_MIN = 3'd2;
  localparam logic [EXT_W-1:0] EXT_LEN_MAX = 3'd3;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [0:0] {
    CFG_NAME_LIMIT    = 1'b0,
    CFG_VERSION_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_NAME    = 2'd1,
    PH_VERSION = 2'd2
  } phase_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  length;
    logic [EXTLEN_W-1:0] ext_len;
  } res_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

// ===== src/filename_token_scanner.sv =====
// filename_token_scanner: top level, byte-wise filename token detection
// depends on fts_pkg
//
// Usage: one byte word enters on the input channel (data_byte_i, last_byte_i)
// whenever in_valid_i is high and in_stall_o is low. Each byte updates the
// token state; a closed and accepted token is written into the result
// register and shown on the output channel (token_offset_o, token_length_o,
// extension_length_o). Throughput is one byte per cycle while in_stall_o is
// low. A result that arrives while the output word waits under out_stall_i
// moves into a one-word skid register, so bytes keep flowing; in_stall_o
// rises only while the skid register is occupied. A byte with last_byte_i
// set closes any open token and restarts byte offsets at zero for the next
// buffer. Offsets saturate at 2^24-1.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) sets the name
// limit (index 0) and version limit (index 1), taking effect on the next byte.
// Reset clears both output valid flags, idles the scanner, zeroes the byte offset
// and loads the limits with 32 and 34.
`timescale 1ns / 1ps

module filename_token_scanner
  import fts_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [COUNT_W-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OFFSET_W-1:0] token_offset_o,
  output logic [COUNT_W-1:0]  token_length_o,
  output logic [EXTLEN_W-1:0] extension_length_o
);

  localparam int unsigned CMP_W = (POSITION_WIDTH > OFFSET_W) ? POSITION_WIDTH : OFFSET_W;

  logic [COUNT_W-1:0] name_lim_q, ver_lim_q;

  logic [POSITION_WIDTH-1:0] pos_q, pos_d, start_q, start_d;
  logic [COUNT_W-1:0]        cnt_q, cnt_d;
  phase_e                    phase_q, phase_d;
  logic                      dot_q, dot_d;
  logic [EXT_W-1:0]          ext_q, ext_d;
  logic                      up_q, up_d;

  logic               tk_taken, tk_lim, tk_ver;
  logic [COUNT_W-1:0] tk_cnt;
  logic               tk_dot, tk_up;
  logic [EXT_W-1:0]   tk_ext;
  logic               judge, tok_ok, result;
  logic               c_upper, c_digit;
  logic [CMP_W-1:0]   start_ext;
  res_t               new_res;

  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic in_acc, out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_lim_q <= NAME_LIMIT_RST;
      ver_lim_q  <= VERSION_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NAME_LIMIT:    name_lim_q <= cfg_data_i;
        CFG_VERSION_LIMIT: ver_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    c_upper  = is_upper(data_byte_i);
    c_digit  = is_digit(data_byte_i);
    tk_taken = 1'b0;
    tk_lim   = 1'b0;
    tk_ver   = 1'b0;
    tk_cnt   = cnt_q + 1'b1;
    tk_dot   = dot_q;
    tk_ext   = ext_q;
    tk_up    = up_q;

    unique case (phase_q)
      PH_NAME: begin
        if (c_upper || c_digit || (data_byte_i == CH_UNDER)) begin
          tk_taken = 1'b1;
          if (dot_q) begin
            if (ext_q < EXT_SAT) tk_ext = ext_q + 1'b1;
            if (!c_upper) tk_up = 1'b0;
          end
          tk_lim = tk_cnt >= name_lim_q;
        end else if ((data_byte_i == CH_DOT) && !dot_q) begin
          tk_taken = 1'b1;
          tk_dot   = 1'b1;
          tk_lim   = tk_cnt >= name_lim_q;
        end else if ((data_byte_i == CH_SEMI) && dot_q) begin
          tk_taken = 1'b1;
          tk_ver   = 1'b1;
          tk_lim   = tk_cnt >= ver_lim_q;
        end
      end
      PH_VERSION: begin
        if (c_digit) begin
          tk_taken = 1'b1;
          tk_lim   = tk_cnt >= ver_lim_q;
        end
      end
      default: ;
    endcase

    if (!tk_taken) tk_cnt = cnt_q;

    judge  = tk_taken ? (tk_lim || last_byte_i) : (phase_q != PH_IDLE);
    tok_ok = tk_dot && (tk_cnt >= MIN_TOKEN_LEN) && (tk_ext >= EXT_LEN_MIN) &&
             (tk_ext <= EXT_LEN_MAX) && tk_up;
    result = judge && tok_ok;

    start_ext       = CMP_W'(start_q);
    new_res.offset  = (start_ext > CMP_W'(OFFSET_MAX)) ? OFFSET_MAX : OFFSET_W'(start_ext);
    new_res.length  = tk_cnt;
    new_res.ext_len = EXTLEN_W'(tk_ext);

    start_d = start_q;
    cnt_d   = tk_cnt;
    dot_d   = tk_dot;
    ext_d   = tk_ext;
    up_d    = tk_up;
    if (tk_taken) begin
      if (tk_lim || last_byte_i) phase_d = PH_IDLE;
      else if (tk_ver)           phase_d = PH_VERSION;
      else                       phase_d = phase_q;
    end else if (c_upper || c_digit) begin
      start_d = pos_q;
      cnt_d   = COUNT_W'(1);
      dot_d   = 1'b0;
      ext_d   = '0;
      up_d    = 1'b1;
      phase_d = ((COUNT_W'(1) >= name_lim_q) || last_byte_i) ? PH_IDLE : PH_NAME;
    end else begin
      phase_d = PH_IDLE;
    end

    if (last_byte_i)     pos_d = '0;
    else if (pos_q != '1) pos_d = pos_q + 1'b1;
    else                 pos_d = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      phase_q <= PH_IDLE;
      dot_q   <= 1'b0;
      ext_q   <= '0;
      up_q    <= 1'b1;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      dot_q   <= dot_d;
      ext_q   <= ext_d;
      up_q    <= up_d;
    end
  end

  // result register plus one-word skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc && result;
        end
      end else if (in_acc && result) begin
        if (out_valid_q) skid_valid_q <= 1'b1;
        else             out_valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_acc && result) out_q <= new_res;
    end else if (in_acc && result) begin
      if (out_valid_q) skid_q <= new_res;
      else             out_q  <= new_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign token_offset_o     = out_q.offset;
  assign token_length_o     = out_q.length;
  assign extension_length_o = out_q.ext_len;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_out_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.length >= MIN_TOKEN_LEN))
    else $error("reported token shorter than minimum");

  a_out_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.ext_len == 2'd2) || (out_q.ext_len == 2'd3)))
    else $error("reported extension length out of range");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> ((pos_q == '0) && (phase_q == PH_IDLE)))
    else $error("last byte did not restart the scanner");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_fire) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid word lost while output stalled");

endmodule
